/* rtl/psgw_pkg.sv */
// Shared types and constants for the scatter-gather descriptor table walker.
// Holds the item and result records and the action codes; no dependencies.
package psgw_pkg;

    localparam int unsigned AddrW      = 64;
    localparam int unsigned LenW       = 32;
    localparam int unsigned CountW     = 16;
    localparam int unsigned ByteCountW = 19;
    localparam int unsigned SizeW      = 18;
    localparam int unsigned InDataW    = 232;
    localparam int unsigned OutDataW   = 120;
    localparam int unsigned FifoDepth  = 4;
    localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
    localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

    localparam logic [AddrW-1:0]      EntryBytes      = 64'd16;
    localparam logic [ByteCountW-1:0] EntryBytesCount = 19'd16;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_ENTRY = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ACT_FETCH   = 3'd0,
        ACT_XFER    = 3'd1,
        ACT_OK      = 3'd2,
        ACT_SHORT   = 3'd3,
        ACT_IGNORED = 3'd4
    } action_t;

    typedef struct packed {
        kind_t              kind;
        logic [AddrW-1:0]   descriptor_base;
        logic [CountW-1:0]  table_offset;
        logic [CountW-1:0]  entry_count;
        logic [LenW-1:0]    total_length;
        logic               to_memory;
        logic [31:0]        entry_addr_low;
        logic [31:0]        entry_addr_high;
        logic [31:0]        entry_size_raw;
    } item_t;

    typedef struct packed {
        action_t                 action;
        logic [AddrW-1:0]        mem_address;
        logic [ByteCountW-1:0]   byte_count;
        logic [LenW-1:0]         buffer_offset;
        logic                    write_dir;
        logic                    last;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } res_push_t;

endpackage

/* rtl/psgw_walk.sv */
// Walk state and per-item decision logic for the descriptor table walker.
// Uses psgw_pkg; produces up to two result records per consumed item.
module psgw_walk (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               consume,
    input  psgw_pkg::item_t    item,
    output psgw_pkg::res_push_t push
);

    logic [psgw_pkg::AddrW-1:0]  fetch_ptr_reg, fetch_ptr_next;
    logic [psgw_pkg::LenW-1:0]   remaining_reg, remaining_next;
    logic [psgw_pkg::LenW-1:0]   done_reg, done_next;
    logic [psgw_pkg::CountW-1:0] entries_reg, entries_next;
    logic                        dir_reg, dir_next;
    logic                        active_reg, active_next;

    always_comb begin
        psgw_pkg::result_t            res_a;
        psgw_pkg::result_t            res_b;
        psgw_pkg::result_t            adv;
        logic [psgw_pkg::ByteCountW-1:0] size_p1;
        logic [psgw_pkg::LenW-1:0]    chunk;
        logic [psgw_pkg::LenW-1:0]    rem_new;
        logic [psgw_pkg::LenW-1:0]    done_new;
        logic [psgw_pkg::CountW-1:0]  ent_new;
        logic [psgw_pkg::AddrW-1:0]   ptr_new;
        logic                         act_new;

        fetch_ptr_next = fetch_ptr_reg;
        remaining_next = remaining_reg;
        done_next      = done_reg;
        entries_next   = entries_reg;
        dir_next       = dir_reg;
        active_next    = active_reg;

        res_a = '0;
        res_b = '0;
        adv   = '0;
        push  = '0;

        size_p1 = {1'b0, item.entry_size_raw[psgw_pkg::SizeW-1:0]} + 19'd1;
        chunk = ({13'd0, size_p1} > remaining_reg) ? remaining_reg : {13'd0, size_p1};

        if (item.kind == psgw_pkg::KIND_START) begin
            ptr_new  = item.descriptor_base + {46'd0, item.table_offset, 2'b00};
            rem_new  = item.total_length;
            done_new = '0;
            ent_new  = item.entry_count;
        end else begin
            ptr_new  = fetch_ptr_reg + psgw_pkg::EntryBytes;
            rem_new  = remaining_reg - chunk;
            done_new = done_reg + chunk;
            ent_new  = entries_reg - 16'd1;
        end

        // The decision that follows a start or an entry: next fetch or completion.
        act_new  = 1'b1;
        adv.last = 1'b1;
        if (rem_new == '0) begin
            adv.action        = psgw_pkg::ACT_OK;
            adv.buffer_offset = done_new;
            act_new           = 1'b0;
        end else if (ent_new == '0) begin
            adv.action        = psgw_pkg::ACT_SHORT;
            adv.buffer_offset = done_new;
            act_new           = 1'b0;
        end else begin
            adv.action      = psgw_pkg::ACT_FETCH;
            adv.mem_address = ptr_new;
            adv.byte_count  = psgw_pkg::EntryBytesCount;
        end

        if (item.kind == psgw_pkg::KIND_START) begin
            res_a    = adv;
            push.num = 2'd1;
        end else if (!active_reg) begin
            res_a.action = psgw_pkg::ACT_IGNORED;
            res_a.last   = 1'b1;
            push.num     = 2'd1;
        end else begin
            res_a.action        = psgw_pkg::ACT_XFER;
            res_a.mem_address   = {item.entry_addr_high, item.entry_addr_low};
            res_a.byte_count    = chunk[psgw_pkg::ByteCountW-1:0];
            res_a.buffer_offset = done_reg;
            res_a.write_dir     = dir_reg;
            res_a.last          = 1'b0;
            res_b               = adv;
            push.num            = 2'd2;
        end

        if (!consume) begin
            push.num = 2'd0;
        end
        push.first  = res_a;
        push.second = res_b;

        if (consume && (item.kind == psgw_pkg::KIND_START || active_reg)) begin
            fetch_ptr_next = ptr_new;
            remaining_next = rem_new;
            done_next      = done_new;
            entries_next   = ent_new;
            active_next    = act_new;
            if (item.kind == psgw_pkg::KIND_START) begin
                dir_next = item.to_memory;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fetch_ptr_reg <= '0;
            remaining_reg <= '0;
            done_reg      <= '0;
            entries_reg   <= '0;
            dir_reg       <= 1'b0;
            active_reg    <= 1'b0;
        end else begin
            fetch_ptr_reg <= fetch_ptr_next;
            remaining_reg <= remaining_next;
            done_reg      <= done_next;
            entries_reg   <= entries_next;
            dir_reg       <= dir_next;
            active_reg    <= active_next;
        end
    end

    // A completion always leaves the walker idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num != 2'd0 && (push.first.action == psgw_pkg::ACT_OK ||
         push.first.action == psgw_pkg::ACT_SHORT ||
         push.second.action == psgw_pkg::ACT_OK ||
         push.second.action == psgw_pkg::ACT_SHORT)) |=> !active_reg)
        else $error("walker still active after completion");

    // Bytes moved plus bytes remaining stay equal to the programmed length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && item.kind == psgw_pkg::KIND_ENTRY && active_reg) |=>
        (remaining_reg + done_reg == $past(remaining_reg + done_reg)))
        else $error("transfer length not conserved");

endmodule

/* rtl/psgw_fifo.sv */
// Result queue of the descriptor table walker: takes up to two records a
// cycle and hands out one per beat. Uses psgw_pkg.
module psgw_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  psgw_pkg::res_push_t         push,
    output logic                        room,
    output logic                        out_valid,
    input  logic                        out_ready,
    output psgw_pkg::result_t           out_res
);

    psgw_pkg::result_t                  store_reg [psgw_pkg::FifoDepth];
    logic [psgw_pkg::FifoPtrW-1:0]      wr_reg, wr_next;
    logic [psgw_pkg::FifoPtrW-1:0]      rd_reg, rd_next;
    logic [psgw_pkg::FifoCntW-1:0]      count_reg, count_next;
    logic                               pop;
    logic [psgw_pkg::FifoPtrW-1:0]      wr_second;

    assign room      = (count_reg <= psgw_pkg::FifoCntW'(psgw_pkg::FifoDepth - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = store_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign wr_second = wr_reg + psgw_pkg::FifoPtrW'(1);

    always_comb begin
        wr_next    = wr_reg + psgw_pkg::FifoPtrW'(push.num);
        rd_next    = pop ? rd_reg + psgw_pkg::FifoPtrW'(1) : rd_reg;
        count_next = count_reg + psgw_pkg::FifoCntW'(push.num)
                     - psgw_pkg::FifoCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            store_reg[wr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            store_reg[wr_second] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.num != 2'd0) |-> room)
        else $error("result queue written without room");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_reg - rd_reg) == count_reg[psgw_pkg::FifoPtrW-1:0])
        else $error("result queue pointers and count disagree");

endmodule

/* rtl/prdt_scatter_gather_walker.sv */
// Scatter-gather descriptor table walker, top level; uses psgw_pkg,
// psgw_walk and psgw_fifo. A beat is registered in item_reg on accept and is
// decided once the result queue has room, which writes its results into it.
// A start beat can be taken every cycle while the result side keeps accepting;
// an entry beat in a walk yields two result beats, so entry beats go slower.
// Synchronous active-low reset empties the pipeline and leaves the walker idle.
module prdt_scatter_gather_walker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // descriptor_base, table_offset, entry_count, total_length, to_memory,
    // entry_addr_low, entry_addr_high, entry_size_raw, zero fill
    input  logic [psgw_pkg::InDataW-1:0]   s_axis_tdata,
    // kind
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // mem_address, byte_count, buffer_offset, write_dir, zero fill
    output logic [psgw_pkg::OutDataW-1:0]  m_axis_tdata,
    // action
    output logic [2:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);

    psgw_pkg::item_t     item_reg;
    logic                item_valid_reg, item_valid_next;
    logic                room;
    logic                consume;
    psgw_pkg::res_push_t push;
    psgw_pkg::result_t   out_res;

    assign consume       = item_valid_reg && room;
    assign s_axis_tready = !item_valid_reg || consume;

    always_comb begin
        item_valid_next = item_valid_reg;
        if (s_axis_tready) begin
            item_valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg.kind            <= psgw_pkg::kind_t'(s_axis_tuser);
            item_reg.descriptor_base <= s_axis_tdata[63:0];
            item_reg.table_offset    <= s_axis_tdata[79:64];
            item_reg.entry_count     <= s_axis_tdata[95:80];
            item_reg.total_length    <= s_axis_tdata[127:96];
            item_reg.to_memory       <= s_axis_tdata[128];
            item_reg.entry_addr_low  <= s_axis_tdata[160:129];
            item_reg.entry_addr_high <= s_axis_tdata[192:161];
            item_reg.entry_size_raw  <= s_axis_tdata[224:193];
        end
    end

    psgw_walk u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .consume (consume),
        .item    (item_reg),
        .push    (push)
    );

    psgw_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {4'd0, out_res.write_dir, out_res.buffer_offset,
                           out_res.byte_count, out_res.mem_address};
    assign m_axis_tuser = out_res.action;
    assign m_axis_tlast = out_res.last;

endmodule

/* tb/psgw_walk_checker.sv */
// Scoreboard for the scatter-gather table walker: watches both stream channels,
// predicts each result beat from the accepted input beats and compares them.
// Depends on psgw_pkg for the item, result and action types.
module psgw_walk_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [psgw_pkg::InDataW-1:0]   s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [psgw_pkg::OutDataW-1:0]  m_axis_tdata,
    input  logic [2:0]                     m_axis_tuser,
    input  logic                           m_axis_tlast,
    output int                             fail_count,
    output int                             results_pending
);

    logic [psgw_pkg::AddrW-1:0]  tbl_addr;
    logic [psgw_pkg::LenW-1:0]   bytes_left;
    logic [psgw_pkg::LenW-1:0]   bytes_moved;
    logic [psgw_pkg::CountW-1:0] entries_left;
    logic [psgw_pkg::CountW-1:0] entry_idx;
    logic                        dir_to_mem;
    logic                        walking;
    psgw_pkg::result_t           awaited_results[$];
    int                          mismatches = 0;

    assign fail_count = mismatches;

    function automatic psgw_pkg::result_t pack_result(
        psgw_pkg::action_t act, logic [psgw_pkg::AddrW-1:0] addr,
        logic [psgw_pkg::ByteCountW-1:0] cnt,
        logic [psgw_pkg::LenW-1:0] off, logic dir, logic lst);
        psgw_pkg::result_t r;
        r.action        = act;
        r.mem_address   = addr;
        r.byte_count    = cnt;
        r.buffer_offset = off;
        r.write_dir     = dir;
        r.last          = lst;
        return r;
    endfunction

    // After a start or a chunk the walk either finishes or asks for the next entry.
    task automatic close_or_fetch();
        if (bytes_left == '0) begin
            awaited_results.push_back(pack_result(psgw_pkg::ACT_OK, '0, '0, bytes_moved,
                                                  1'b0, 1'b1));
            walking = 1'b0;
        end else if (entries_left == '0) begin
            awaited_results.push_back(pack_result(psgw_pkg::ACT_SHORT, '0, '0, bytes_moved,
                                                  1'b0, 1'b1));
            walking = 1'b0;
        end else begin
            awaited_results.push_back(pack_result(psgw_pkg::ACT_FETCH,
                                                  tbl_addr + {44'd0, entry_idx, 4'd0},
                                                  psgw_pkg::EntryBytesCount, '0, 1'b0,
                                                  1'b1));
        end
    endtask

    task automatic predict_walk(input psgw_pkg::item_t it);
        logic [psgw_pkg::LenW-1:0] chunk;
        if (it.kind == psgw_pkg::KIND_START) begin
            tbl_addr     = it.descriptor_base + {46'd0, it.table_offset, 2'b00};
            bytes_left   = it.total_length;
            bytes_moved  = '0;
            entries_left = it.entry_count;
            entry_idx    = '0;
            dir_to_mem   = it.to_memory;
            walking      = 1'b1;
            close_or_fetch();
        end else if (!walking) begin
            awaited_results.push_back(pack_result(psgw_pkg::ACT_IGNORED, '0, '0, '0, 1'b0,
                                                  1'b1));
        end else begin
            chunk = {14'd0, it.entry_size_raw[psgw_pkg::SizeW-1:0]} + 32'd1;
            if (chunk > bytes_left) begin
                chunk = bytes_left;
            end
            awaited_results.push_back(pack_result(psgw_pkg::ACT_XFER,
                                                  {it.entry_addr_high, it.entry_addr_low},
                                                  chunk[psgw_pkg::ByteCountW-1:0],
                                                  bytes_moved, dir_to_mem, 1'b0));
            bytes_moved  = bytes_moved + chunk;
            bytes_left   = bytes_left - chunk;
            entries_left = entries_left - 16'd1;
            entry_idx    = entry_idx + 16'd1;
            close_or_fetch();
        end
    endtask

    always @(posedge aclk) begin : watch
        psgw_pkg::item_t   it;
        psgw_pkg::result_t seen;
        psgw_pkg::result_t want;
        if (!aresetn) begin
            tbl_addr     = '0;
            bytes_left   = '0;
            bytes_moved  = '0;
            entries_left = '0;
            entry_idx    = '0;
            dir_to_mem   = 1'b0;
            walking      = 1'b0;
            awaited_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen = pack_result(psgw_pkg::action_t'(m_axis_tuser), m_axis_tdata[63:0],
                                   m_axis_tdata[82:64], m_axis_tdata[114:83],
                                   m_axis_tdata[115], m_axis_tlast);
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, seen);
                    mismatches = mismatches + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (seen !== want) begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, want, seen);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                it.kind            = psgw_pkg::kind_t'(s_axis_tuser);
                it.descriptor_base = s_axis_tdata[63:0];
                it.table_offset    = s_axis_tdata[79:64];
                it.entry_count     = s_axis_tdata[95:80];
                it.total_length    = s_axis_tdata[127:96];
                it.to_memory       = s_axis_tdata[128];
                it.entry_addr_low  = s_axis_tdata[160:129];
                it.entry_addr_high = s_axis_tdata[192:161];
                it.entry_size_raw  = s_axis_tdata[224:193];
                predict_walk(it);
            end
        end
        results_pending = awaited_results.size();
    end

endmodule

/* tb/prdt_scatter_gather_walker_test.sv */
// Testbench top for the scatter-gather table walker: drives start and entry
// beats with random gaps and a back-pressured result side, and gives the verdict.
// Depends on psgw_pkg, prdt_scatter_gather_walker and psgw_walk_checker.
module prdt_scatter_gather_walker_test;

    logic                           aclk          = 1'b0;
    logic                           aresetn       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [psgw_pkg::InDataW-1:0]   s_axis_tdata  = '0;
    logic                           s_axis_tuser  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [psgw_pkg::OutDataW-1:0]  m_axis_tdata;
    logic [2:0]                     m_axis_tuser;
    logic                           m_axis_tlast;
    int                             fail_count;
    int                             results_pending;
    int                             beats_sent    = 0;
    logic                           steady_send   = 1'b0;
    logic                           steady_recv   = 1'b0;

    always #10 aclk = ~aclk;

    prdt_scatter_gather_walker u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    psgw_walk_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    function automatic psgw_pkg::item_t random_item();
        psgw_pkg::item_t it;
        logic [31:0]     rnd;
        rnd                = $urandom;
        it.kind            = psgw_pkg::kind_t'(rnd[0]);
        it.to_memory       = rnd[1];
        it.table_offset    = rnd[31:16];
        it.descriptor_base = {$urandom, $urandom};
        rnd                = $urandom;
        it.entry_count     = rnd[15:0];
        it.total_length    = $urandom;
        it.entry_addr_low  = $urandom;
        it.entry_addr_high = $urandom;
        it.entry_size_raw  = $urandom;
        return it;
    endfunction

    function automatic psgw_pkg::item_t start_item(logic [63:0] base, logic [15:0] offset,
                                                   logic [15:0] count, logic [31:0] length,
                                                   logic dir);
        psgw_pkg::item_t it;
        it                 = random_item();
        it.kind            = psgw_pkg::KIND_START;
        it.descriptor_base = base;
        it.table_offset    = offset;
        it.entry_count     = count;
        it.total_length    = length;
        it.to_memory       = dir;
        return it;
    endfunction

    function automatic psgw_pkg::item_t entry_item(logic [63:0] addr, logic [31:0] size_raw);
        psgw_pkg::item_t it;
        it                 = random_item();
        it.kind            = psgw_pkg::KIND_ENTRY;
        it.entry_addr_low  = addr[31:0];
        it.entry_addr_high = addr[63:32];
        it.entry_size_raw  = size_raw;
        return it;
    endfunction

    task automatic offer_beat(input psgw_pkg::item_t it);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {7'd0, it.entry_size_raw, it.entry_addr_high, it.entry_addr_low,
                          it.to_memory, it.total_length, it.entry_count,
                          it.table_offset, it.descriptor_base};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        beats_sent = beats_sent + 1;
        if (beats_sent % 40 == 0) begin
            steady_send = ($urandom_range(0, 3) == 0);
        end
    endtask

    // One table walk: entry sizes are drawn first so that the length can be set
    // to finish exactly, early, too late, or be cut off by the next start.
    task automatic run_walk();
        logic [31:0] raws[6];
        logic [31:0] covered;
        logic [31:0] length;
        logic [31:0] pick;
        int          n;
        int          mode;
        int          sent_entries;
        covered = '0;
        pick    = $urandom_range(1, 6);
        n       = pick;
        for (int i = 0; i < n; i++) begin
            raws[i] = $urandom;
            case ($urandom_range(0, 7))
                0: raws[i][17:0] = 18'h3ffff;
                1: raws[i][17:0] = 18'h0;
                default: raws[i][17:0] = 18'($urandom_range(0, 300));
            endcase
            covered = covered + {14'd0, raws[i][17:0]} + 32'd1;
        end
        mode = $urandom_range(0, 9);
        length = covered;
        if (mode == 5 || mode == 6) begin
            length = covered + $urandom_range(1, 1000);
        end else if (mode == 7 || mode == 8) begin
            length = $urandom_range(1, covered);
        end
        offer_beat(start_item({$urandom, $urandom}, 16'($urandom), pick[15:0], length,
                              1'($urandom)));
        sent_entries = (mode == 9) ? $urandom_range(0, n - 1) : n;
        for (int i = 0; i < sent_entries; i++) begin
            offer_beat(entry_item({$urandom, $urandom}, raws[i]));
        end
        if ($urandom_range(0, 9) == 0) begin
            offer_beat(entry_item({$urandom, $urandom}, $urandom));
        end
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Entry while idle, zero length, zero entries, and wrapping table addresses.
        offer_beat(entry_item({$urandom, $urandom}, $urandom));
        offer_beat(start_item(64'h0123_4567_89ab_cdef, 16'h0010, 16'd5, 32'd0, 1'b1));
        offer_beat(start_item(64'h0000_0000_1000_0000, 16'h0004, 16'd0, 32'd100, 1'b0));
        offer_beat(start_item({64{1'b1}}, 16'hffff, 16'd3, 32'hffff_ffff, 1'b1));
        offer_beat(entry_item({64{1'b1}}, 32'hffff_ffff));
        offer_beat(entry_item(64'd0, 32'h0000_0000));
        offer_beat(entry_item(64'h8000_0000_0000_0001, 32'hfffc_0000 | 32'h3ffff));
        offer_beat(start_item(64'd0, 16'd0, 16'hffff, 32'd10, 1'b0));
        offer_beat(entry_item(64'h0000_0000_dead_beef, 32'h0000_00ff));
        offer_beat(entry_item(64'h1111_2222_3333_4444, 32'd7));
        offer_beat(start_item(64'h0000_0040_0000_0000, 16'h0100, 16'd2, 32'd1000, 1'b1));
        offer_beat(entry_item(64'h0000_0000_0000_1000, 32'd9));
        offer_beat(start_item(64'h0000_0000_0000_2000, 16'h0002, 16'd1, 32'd5, 1'b0));
        offer_beat(entry_item(64'h0000_0000_0000_3000, 32'd4));
        offer_beat(start_item(64'hffff_ffff_ffff_fff0, 16'd0, 16'd4, 32'd64, 1'b1));
        offer_beat(entry_item(64'h0000_0000_0000_4000, 32'd15));
        offer_beat(entry_item(64'h0000_0000_0000_5000, 32'hfffc_000f));
        offer_beat(entry_item(64'h0000_0000_0000_6000, 32'd31));

        while (beats_sent < 650) begin
            if ($urandom_range(0, 99) < 85) begin
                run_walk();
            end else begin
                offer_beat(random_item());
            end
        end
        s_axis_tvalid <= 1'b0;

        while (results_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("prdt_scatter_gather_walker_test: clean");
        end else begin
            $display("prdt_scatter_gather_walker_test: errors");
        end
        $finish;
    end

    // Result side: random stalls per beat, calm stretches, and two long hold-offs
    // during which the sender keeps offering so the block backs up.
    initial begin : result_sink
        int stall;
        int beats_taken;
        beats_taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (beats_taken == 120 || beats_taken == 600) begin
                stall = 80;
            end else begin
                stall = steady_recv ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            beats_taken = beats_taken + 1;
            if (beats_taken % 40 == 0) begin
                steady_recv = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin : watchdog
        #4000000;
        $display("prdt_scatter_gather_walker_test: errors");
        $finish;
    end

endmodule
